// File: hw/rtl/tsfs_pkg.sv
`default_nettype none

package tsfs_pkg;

    // fixed field widths
    localparam int unsigned RAW_W    = 12;
    localparam int unsigned PRESS_W  = 13;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned SCREEN_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned ROT_W    = 2;

    // filter constants
    localparam logic [TIME_W-1:0]  HOLDOFF_MS   = 32'd3;
    localparam logic [PRESS_W-1:0] WAKE_Z_LEVEL = 13'd75;
    localparam logic [PRESS_W-1:0] Z_OFFSET     = 13'd4095;

    // scaling unit sizing
    localparam int unsigned PROD_W     = 26;
    localparam int unsigned QMAG_W     = 24;
    localparam int unsigned Q_W        = QMAG_W + 1;
    localparam int unsigned BITS_PER_CYC = 2;
    localparam int unsigned DIV_CYCLES = QMAG_W / BITS_PER_CYC;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOUCH_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATION        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH_PX        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_PX       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_X_MIN           = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_X_MAX           = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MIN           = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MAX           = 3'd7;

    // register reset values
    localparam logic [PRESS_W-1:0] RST_TOUCH_THRESHOLD = 13'd400;
    localparam logic [ROT_W-1:0]   RST_ROTATION        = 2'd1;
    localparam logic [RAW_W-1:0]   RST_WIDTH_PX        = 12'd320;
    localparam logic [RAW_W-1:0]   RST_HEIGHT_PX       = 12'd240;
    localparam logic [RAW_W-1:0]   RST_X_MIN           = 12'd200;
    localparam logic [RAW_W-1:0]   RST_X_MAX           = 12'd3700;
    localparam logic [RAW_W-1:0]   RST_Y_MIN           = 12'd240;
    localparam logic [RAW_W-1:0]   RST_Y_MAX           = 12'd3800;

    // command codes
    localparam logic CMD_PEN  = 1'b0;
    localparam logic CMD_MEAS = 1'b1;

    // rotation codes
    localparam logic [ROT_W-1:0] ROT_PORTRAIT       = 2'd0;
    localparam logic [ROT_W-1:0] ROT_LANDSCAPE      = 2'd1;
    localparam logic [ROT_W-1:0] ROT_PORTRAIT_FLIP  = 2'd2;
    localparam logic [ROT_W-1:0] ROT_LANDSCAPE_FLIP = 2'd3;

    typedef struct packed {
        logic              cmd;
        logic [TIME_W-1:0] now_ms;
        logic [RAW_W-1:0]  z1_raw;
        logic [RAW_W-1:0]  z2_raw;
        logic [RAW_W-1:0]  x_a;
        logic [RAW_W-1:0]  y_a;
        logic [RAW_W-1:0]  x_b;
        logic [RAW_W-1:0]  y_b;
        logic [RAW_W-1:0]  x_c;
        logic [RAW_W-1:0]  y_c;
    } t_in_beat;

    typedef struct packed {
        logic                       sample_taken;
        logic                       is_touched;
        logic [PRESS_W-1:0]         pressure;
        logic [RAW_W-1:0]           x_held;
        logic [RAW_W-1:0]           y_held;
        logic signed [SCREEN_W-1:0] x_screen;
        logic signed [SCREEN_W-1:0] y_screen;
    } t_out_beat;

    // request to the shared scaling unit
    typedef struct packed {
        logic             start;
        logic [RAW_W-1:0] v;
        logic [RAW_W-1:0] lo;
        logic [RAW_W-1:0] hi;
        logic [RAW_W-1:0] size;
    } t_scale_req;

    typedef struct packed {
        logic                  done;
        logic signed [Q_W-1:0] q;
    } t_scale_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START_X,
        ST_RUN_X,
        ST_START_Y,
        ST_RUN_Y,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        SC_IDLE,
        SC_MUL,
        SC_DIV,
        SC_DONE
    } t_sc_state;

endpackage

`default_nettype wire

// File: hw/rtl/tsfs_filter.sv
`default_nettype none

module tsfs_filter (
    input  var tsfs_pkg::t_in_beat                 i_beat,
    output logic [tsfs_pkg::PRESS_W-1:0]           o_pressure,
    output logic [tsfs_pkg::RAW_W-1:0]             o_x_mean,
    output logic [tsfs_pkg::RAW_W-1:0]             o_y_mean
);
    import tsfs_pkg::*;

    function automatic logic [RAW_W-1:0] absdiff(input logic [RAW_W-1:0] a,
                                                 input logic [RAW_W-1:0] b);
        absdiff = (a > b) ? (a - b) : (b - a);
    endfunction

    // mean of the closest pair, ties go to a-b then a-c
    function automatic logic [RAW_W-1:0] pair_mean(input logic [RAW_W-1:0] a,
                                                   input logic [RAW_W-1:0] b,
                                                   input logic [RAW_W-1:0] c);
        logic [RAW_W-1:0] dab;
        logic [RAW_W-1:0] dac;
        logic [RAW_W-1:0] dbc;
        logic [RAW_W:0]   sum;
        dab = absdiff(a, b);
        dac = absdiff(a, c);
        dbc = absdiff(b, c);
        if (dab <= dac && dab <= dbc) begin
            sum = {1'b0, a} + {1'b0, b};
        end else if (dac <= dbc) begin
            sum = {1'b0, a} + {1'b0, c};
        end else begin
            sum = {1'b0, b} + {1'b0, c};
        end
        pair_mean = sum[RAW_W:1];
    endfunction

    // z2 never exceeds the offset, so the sum stays non-negative
    assign o_pressure = {1'b0, i_beat.z1_raw} + Z_OFFSET - {1'b0, i_beat.z2_raw};
    assign o_x_mean   = pair_mean(i_beat.x_a, i_beat.x_b, i_beat.x_c);
    assign o_y_mean   = pair_mean(i_beat.y_a, i_beat.y_b, i_beat.y_c);

endmodule

`default_nettype wire

// File: hw/rtl/tsfs_scale.sv
`default_nettype none

module tsfs_scale (
    input  var logic                 i_clk,
    input  var logic                 i_rst_n,
    input  var tsfs_pkg::t_scale_req i_req,
    output tsfs_pkg::t_scale_rsp     o_rsp
);
    import tsfs_pkg::*;

    t_sc_state r_state;
    t_sc_state n_state;

    logic signed [RAW_W:0]    r_diff;
    logic signed [RAW_W:0]    r_span;
    logic [RAW_W-1:0]         r_size;
    logic [QMAG_W-1:0]        r_num;
    logic [RAW_W:0]           r_rem;
    logic [RAW_W-1:0]         r_den;
    logic                     r_neg;
    logic                     r_zero;
    logic [DIV_CNT_W-1:0]     r_cnt;

    logic signed [PROD_W-1:0] prod;
    logic [PROD_W-1:0]        prod_mag;
    logic [RAW_W:0]           span_mag;
    logic [QMAG_W-1:0]        n_num;
    logic [RAW_W:0]           n_rem;

    assign prod     = r_diff * $signed({1'b0, r_size});
    assign prod_mag = prod[PROD_W-1] ? (-prod) : prod;
    assign span_mag = r_span[RAW_W] ? (-r_span) : r_span;

    // two restoring steps per cycle
    always_comb begin
        logic [QMAG_W-1:0] num;
        logic [RAW_W:0]    rem;
        logic [RAW_W:0]    sh;
        num = r_num;
        rem = r_rem;
        for (int k = 0; k < BITS_PER_CYC; k++) begin
            sh  = {rem[RAW_W-1:0], num[QMAG_W-1]};
            num = {num[QMAG_W-2:0], 1'b0};
            if (sh >= {1'b0, r_den}) begin
                rem    = sh - {1'b0, r_den};
                num[0] = 1'b1;
            end else begin
                rem = sh;
            end
        end
        n_num = num;
        n_rem = rem;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            SC_IDLE: begin
                if (i_req.start) n_state = SC_MUL;
            end
            SC_MUL:  n_state = SC_DIV;
            SC_DIV: begin
                if (r_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) n_state = SC_DONE;
            end
            SC_DONE: n_state = SC_IDLE;
            default: n_state = SC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            SC_IDLE: begin
                r_diff <= $signed({1'b0, i_req.v}) - $signed({1'b0, i_req.lo});
                r_span <= $signed({1'b0, i_req.hi}) - $signed({1'b0, i_req.lo});
                r_size <= i_req.size;
            end
            SC_MUL: begin
                r_num  <= prod_mag[QMAG_W-1:0];
                r_rem  <= '0;
                r_den  <= span_mag[RAW_W-1:0];
                r_neg  <= prod[PROD_W-1] ^ r_span[RAW_W];
                r_zero <= (r_span == '0);
                r_cnt  <= '0;
            end
            SC_DIV: begin
                r_num <= n_num;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_rsp.done = (r_state == SC_DONE);
        if (r_zero) begin
            o_rsp.q = '0;
        end else if (r_neg) begin
            o_rsp.q = -$signed({1'b0, r_num});
        end else begin
            o_rsp.q = $signed({1'b0, r_num});
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/touch_sample_filter_scaler_core.sv
`default_nettype none
// channel  | direction | handshake                | payload
// ---------+-----------+--------------------------+------------------------
// in       | input     | i_in_valid / o_in_ready   | i_in_data  (t_in_beat)
// out      | output    | o_out_valid / i_out_ready | o_out_data (t_out_beat)
// cfg      | input     | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
// each beat runs the shared scaling unit once per axis: a multiply step, then
// the divider steps (two quotient bits a cycle) for each axis
// synchronous active-low reset; no clearing pass
// the in channel is ready only while the sequencer idles
// a finished beat waits in the output register; the next input beat is taken
// meanwhile, and the sequencer holds in its last state until the slot frees

module touch_sample_filter_scaler_core (
    input  var logic                                  i_clk,
    input  var logic                                  i_rst_n,
    input  var logic                                  i_in_valid,
    output logic                                      o_in_ready,
    input  var tsfs_pkg::t_in_beat                    i_in_data,
    output logic                                      o_out_valid,
    input  var logic                                  i_out_ready,
    output tsfs_pkg::t_out_beat                       o_out_data,
    input  var logic                                  i_cfg_we,
    input  var logic [tsfs_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  var logic [tsfs_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import tsfs_pkg::*;

    // configuration registers
    logic [PRESS_W-1:0] r_touch_threshold;
    logic [ROT_W-1:0]   r_rotation;
    logic [RAW_W-1:0]   r_width_px;
    logic [RAW_W-1:0]   r_height_px;
    logic [RAW_W-1:0]   r_x_min;
    logic [RAW_W-1:0]   r_x_max;
    logic [RAW_W-1:0]   r_y_min;
    logic [RAW_W-1:0]   r_y_max;

    // filter state
    logic               r_awake;
    logic [TIME_W-1:0]  r_last_good_time;
    logic [RAW_W-1:0]   r_held_x;
    logic [RAW_W-1:0]   r_held_y;
    logic [PRESS_W-1:0] r_held_pressure;
    logic               r_taken;

    // sequencer
    t_state r_state;
    t_state n_state;

    logic [SCREEN_W-1:0] r_qx;
    logic [SCREEN_W-1:0] r_qy;
    logic                r_out_valid;
    t_out_beat           r_out;

    logic [PRESS_W-1:0] f_pressure;
    logic [RAW_W-1:0]   f_x_mean;
    logic [RAW_W-1:0]   f_y_mean;

    t_scale_req sc_req;
    t_scale_rsp sc_rsp;

    logic in_acc;
    logic out_load;
    logic meas_ok;
    logic [TIME_W-1:0] elapsed;
    logic [SCREEN_W-1:0] w16;
    logic [SCREEN_W-1:0] h16;
    logic [SCREEN_W-1:0] sx;
    logic [SCREEN_W-1:0] sy;

    tsfs_filter u_filter (
        .i_beat     (i_in_data),
        .o_pressure (f_pressure),
        .o_x_mean   (f_x_mean),
        .o_y_mean   (f_y_mean)
    );

    tsfs_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sc_req),
        .o_rsp   (sc_rsp)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    // wrap-safe hold-off check
    assign elapsed = i_in_data.now_ms - r_last_good_time;
    assign meas_ok = (i_in_data.cmd == CMD_MEAS) && r_awake && (elapsed >= HOLDOFF_MS);

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touch_threshold <= RST_TOUCH_THRESHOLD;
            r_rotation        <= RST_ROTATION;
            r_width_px        <= RST_WIDTH_PX;
            r_height_px       <= RST_HEIGHT_PX;
            r_x_min           <= RST_X_MIN;
            r_x_max           <= RST_X_MAX;
            r_y_min           <= RST_Y_MIN;
            r_y_max           <= RST_Y_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TOUCH_THRESHOLD: r_touch_threshold <= i_cfg_data;
                REG_ROTATION:        r_rotation  <= i_cfg_data[ROT_W-1:0];
                REG_WIDTH_PX:        r_width_px  <= i_cfg_data[RAW_W-1:0];
                REG_HEIGHT_PX:       r_height_px <= i_cfg_data[RAW_W-1:0];
                REG_X_MIN:           r_x_min     <= i_cfg_data[RAW_W-1:0];
                REG_X_MAX:           r_x_max     <= i_cfg_data[RAW_W-1:0];
                REG_Y_MIN:           r_y_min     <= i_cfg_data[RAW_W-1:0];
                REG_Y_MAX:           r_y_max     <= i_cfg_data[RAW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // filter state update at input accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awake          <= 1'b0;
            r_last_good_time <= '0;
            r_held_x         <= '0;
            r_held_y         <= '0;
            r_held_pressure  <= '0;
            r_taken          <= 1'b0;
        end else if (in_acc) begin
            r_taken <= meas_ok;
            if (i_in_data.cmd == CMD_PEN) begin
                r_awake <= 1'b1;
            end else if (meas_ok) begin
                if (f_pressure < r_touch_threshold) begin
                    // released: drop pressure, sleep on a very light touch
                    r_held_pressure <= '0;
                    if (f_pressure < WAKE_Z_LEVEL) r_awake <= 1'b0;
                end else begin
                    r_held_pressure  <= f_pressure;
                    r_held_x         <= f_x_mean;
                    r_held_y         <= f_y_mean;
                    r_last_good_time <= i_in_data.now_ms;
                end
            end
        end
    end

    // sequencer: x axis then y axis through the shared unit
    always_comb begin
        n_state      = r_state;
        sc_req.start = 1'b0;
        sc_req.v     = r_held_x;
        sc_req.lo    = r_x_min;
        sc_req.hi    = r_x_max;
        sc_req.size  = r_width_px;
        out_load     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_START_X;
            end
            ST_START_X: begin
                sc_req.start = 1'b1;
                n_state      = ST_RUN_X;
            end
            ST_RUN_X: begin
                if (sc_rsp.done) n_state = ST_START_Y;
            end
            ST_START_Y: begin
                sc_req.start = 1'b1;
                sc_req.v     = r_held_y;
                sc_req.lo    = r_y_min;
                sc_req.hi    = r_y_max;
                sc_req.size  = r_height_px;
                n_state      = ST_RUN_Y;
            end
            ST_RUN_Y: begin
                if (sc_rsp.done) n_state = ST_DONE;
            end
            ST_DONE: begin
                // wait for a free output slot
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // quotients kept modulo 2^16, the screen results wrap anyway
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN_X && sc_rsp.done) r_qx <= sc_rsp.q[SCREEN_W-1:0];
        if (r_state == ST_RUN_Y && sc_rsp.done) r_qy <= sc_rsp.q[SCREEN_W-1:0];
    end

    assign w16 = {{(SCREEN_W-RAW_W){1'b0}}, r_width_px};
    assign h16 = {{(SCREEN_W-RAW_W){1'b0}}, r_height_px};

    // rotation mapping
    always_comb begin
        case (r_rotation)
            ROT_PORTRAIT: begin
                sx = h16 - r_qy;
                sy = r_qx;
            end
            ROT_LANDSCAPE: begin
                sx = r_qx;
                sy = r_qy;
            end
            ROT_PORTRAIT_FLIP: begin
                sx = r_qy;
                sy = w16 - r_qx;
            end
            default: begin
                sx = w16 - r_qx;
                sy = h16 - r_qy;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.sample_taken <= r_taken;
            r_out.is_touched   <= r_awake && (r_held_pressure >= r_touch_threshold);
            r_out.pressure     <= r_held_pressure;
            r_out.x_held       <= r_held_x;
            r_out.y_held       <= r_held_y;
            r_out.x_screen     <= sx;
            r_out.y_screen     <= sy;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
